// ----- rtl/core/gcsg_pkg.sv -----
// shared types, constants and font functions for the glyph column stream generator
package gcsg_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COL_W       = 8;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] NORMAL_BYTES = 4'd6;
  localparam logic [3:0] DOUBLE_BYTES = 4'd12;
  localparam logic [3:0] GLYPH_COLS   = 4'd5;
  localparam logic [3:0] DOUBLE_COLS  = 4'd10;

  // register index codes (paddr bit 2)
  localparam logic REG_DOUBLE_SIZE = 1'b0;
  localparam logic REG_LOWER_HALF  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

  localparam logic [SLOT_W-1:0] SLOT_BLANK = 6'd0;
  localparam logic [SLOT_W-1:0] SLOT_DIGIT = 6'd1;
  localparam logic [SLOT_W-1:0] SLOT_ALPHA = 6'd11;
  localparam logic [SLOT_W-1:0] SLOT_COLON = 6'd37;
  localparam logic [SLOT_W-1:0] SLOT_DASH  = 6'd38;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              dbl;
    logic              upper_nib;
  } gcsg_entry_t;

  function automatic logic [SLOT_W-1:0] rom_slot(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] off;
    c = code;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      c = c - CASE_FOLD;
    end
    rom_slot = SLOT_BLANK;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      off = c - CH_ZERO;
      rom_slot = SLOT_DIGIT + off[SLOT_W-1:0];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      off = c - CH_UPPER_A;
      rom_slot = SLOT_ALPHA + off[SLOT_W-1:0];
    end else if (c == CH_COLON) begin
      rom_slot = SLOT_COLON;
    end else if (c == CH_DASH) begin
      rom_slot = SLOT_DASH;
    end
  endfunction

  // five glyph columns, leftmost column in the top byte
  function automatic logic [39:0] glyph_row(input logic [SLOT_W-1:0] slot);
    case (slot)
      6'd1:    glyph_row = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      6'd2:    glyph_row = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      6'd3:    glyph_row = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      6'd4:    glyph_row = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      6'd5:    glyph_row = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      6'd6:    glyph_row = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      6'd7:    glyph_row = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      6'd8:    glyph_row = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      6'd9:    glyph_row = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd10:   glyph_row = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      6'd11:   glyph_row = {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
      6'd12:   glyph_row = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd13:   glyph_row = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      6'd14:   glyph_row = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      6'd15:   glyph_row = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      6'd16:   glyph_row = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      6'd17:   glyph_row = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      6'd18:   glyph_row = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd19:   glyph_row = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd20:   glyph_row = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      6'd21:   glyph_row = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      6'd22:   glyph_row = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      6'd23:   glyph_row = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd24:   glyph_row = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      6'd25:   glyph_row = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd26:   glyph_row = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      6'd27:   glyph_row = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      6'd28:   glyph_row = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      6'd29:   glyph_row = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      6'd30:   glyph_row = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd31:   glyph_row = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd32:   glyph_row = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd33:   glyph_row = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      6'd34:   glyph_row = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd35:   glyph_row = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd36:   glyph_row = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      6'd37:   glyph_row = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      6'd38:   glyph_row = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      default: glyph_row = 40'h0;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] glyph_col(input logic [39:0] row,
                                                  input logic [2:0] col);
    case (col)
      3'd0:    glyph_col = row[39:32];
      3'd1:    glyph_col = row[31:24];
      3'd2:    glyph_col = row[23:16];
      3'd3:    glyph_col = row[15:8];
      3'd4:    glyph_col = row[7:0];
      default: glyph_col = '0;
    endcase
  endfunction

  // each pixel bit becomes two bits
  function automatic logic [BYTE_W-1:0] stretch_nibble(input logic [3:0] n);
    stretch_nibble = {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
  endfunction

endpackage

// ----- rtl/core/glyph_column_stream_generator.sv -----
// top level: character stream in, 5x7 font column bytes out, config registers
// Each accepted character yields six column bytes (five glyph columns and one blank
// spacer) in normal size or twelve in double size (five nibble-stretched columns each
// sent twice, then two blank spacers); the last byte of a character carries tlast.
// The output side runs at one byte per cycle while out_tready is high; characters
// dropped because the line already reached COLUMN_LIMIT produce no bytes. A two-entry
// queue between the front end and the column walker lets the next characters be taken
// while bytes of earlier ones are still going out. A transaction with in_tuser high
// starts a new line and clears the column count. Registers: 0x0 double_size, 0x4
// lower_half (selects glyph bits 4-7 in double size); change them only while idle.
module glyph_column_stream_generator #(
  parameter int unsigned COLUMN_LIMIT = 126
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] line_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] column_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                  double_size_r, double_size_nxt;
  logic                  lower_half_r, lower_half_nxt;
  logic                  cfg_wr;
  logic                  push;
  gcsg_pkg::gcsg_entry_t push_entry;
  logic                  queue_full;
  logic                  q_valid;
  gcsg_pkg::gcsg_entry_t q_entry;
  logic                  q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    double_size_nxt = double_size_r;
    lower_half_nxt  = lower_half_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        gcsg_pkg::REG_DOUBLE_SIZE: double_size_nxt = cfg_pwdata[0];
        gcsg_pkg::REG_LOWER_HALF:  lower_half_nxt  = cfg_pwdata[0];
        default:                   double_size_nxt = double_size_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      gcsg_pkg::REG_DOUBLE_SIZE: cfg_prdata = {31'b0, double_size_r};
      gcsg_pkg::REG_LOWER_HALF:  cfg_prdata = {31'b0, lower_half_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_size_r <= 1'b0;
      lower_half_r  <= 1'b0;
    end else begin
      double_size_r <= double_size_nxt;
      lower_half_r  <= lower_half_nxt;
    end
  end

  gcsg_front #(
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .char_code   (in_tdata),
    .line_start  (in_tuser),
    .double_size (double_size_r),
    .lower_half  (lower_half_r),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  gcsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  gcsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ----- rtl/core/gcsg_front.sv -----
// front end: column tracking, line-full drop and font slot lookup
module gcsg_front #(
  parameter int unsigned COLUMN_LIMIT = 126
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gcsg_pkg::CHAR_W-1:0]  char_code,
  input  logic                         line_start,
  input  logic                         double_size,
  input  logic                         lower_half,
  output logic                         push,
  output gcsg_pkg::gcsg_entry_t        push_entry,
  input  logic                         queue_full
);

  logic [gcsg_pkg::COL_W-1:0] col_r;
  logic [gcsg_pkg::COL_W-1:0] col_nxt;
  logic [gcsg_pkg::COL_W-1:0] col_base;
  logic [gcsg_pkg::COL_W:0]   col_sum;
  logic [3:0]                 n_bytes;
  logic                       accept;
  logic                       drop;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign col_base = line_start ? '0 : col_r;
  assign drop     = col_base >= gcsg_pkg::COL_W'(COLUMN_LIMIT);
  assign push     = accept && !drop;
  assign n_bytes  = double_size ? gcsg_pkg::DOUBLE_BYTES : gcsg_pkg::NORMAL_BYTES;
  assign col_sum  = {1'b0, col_base} + {{(gcsg_pkg::COL_W - 3){1'b0}}, n_bytes};

  assign push_entry.slot      = gcsg_pkg::rom_slot(char_code);
  assign push_entry.dbl       = double_size;
  assign push_entry.upper_nib = lower_half;

  always_comb begin
    col_nxt = col_r;
    if (push) begin
      // saturate at all ones
      col_nxt = col_sum[gcsg_pkg::COL_W] ? '1 : col_sum[gcsg_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

endmodule

// ----- rtl/core/gcsg_queue.sv -----
// short queue of classified characters between front and back
module gcsg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gcsg_pkg::gcsg_entry_t push_entry,
  output logic                  full,
  output logic                  pop_valid,
  output gcsg_pkg::gcsg_entry_t pop_entry,
  input  logic                  pop
);

  localparam int unsigned PTR_W = $clog2(gcsg_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(gcsg_pkg::QUEUE_DEPTH + 1);

  gcsg_pkg::gcsg_entry_t mem_r [gcsg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == CNT_W'(gcsg_pkg::QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(gcsg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(gcsg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/gcsg_back.sv -----
// back end: walks the column bytes of one character into an output register
module gcsg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  gcsg_pkg::gcsg_entry_t        q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gcsg_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last
);

  logic                          busy_r, busy_nxt;
  gcsg_pkg::gcsg_entry_t         entry_r;
  logic [gcsg_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [gcsg_pkg::BYTE_W-1:0]   out_byte_r;
  logic                          out_last_r;
  logic                          out_space, produce, finish;
  logic [2:0]                    col;
  logic [gcsg_pkg::BYTE_W-1:0]   glyph_byte;
  logic [gcsg_pkg::BYTE_W-1:0]   cur_byte;
  logic                          cur_last;

  assign out_space = !out_valid_r || out_ready;
  assign produce   = busy_r && out_space;
  assign finish    = produce && cur_last;
  assign q_pop     = q_valid && (!busy_r || finish);

  // in double size each glyph column is sent twice
  assign col        = entry_r.dbl ? idx_r[3:1] : idx_r[2:0];
  assign glyph_byte = gcsg_pkg::glyph_col(gcsg_pkg::glyph_row(entry_r.slot), col);

  always_comb begin
    if (entry_r.dbl) begin
      cur_last = idx_r == gcsg_pkg::DOUBLE_BYTES - 1'b1;
      if (idx_r < gcsg_pkg::DOUBLE_COLS) begin
        cur_byte = gcsg_pkg::stretch_nibble(entry_r.upper_nib ? glyph_byte[7:4]
                                                              : glyph_byte[3:0]);
      end else begin
        cur_byte = '0;
      end
    end else begin
      cur_last = idx_r == gcsg_pkg::NORMAL_BYTES - 1'b1;
      cur_byte = (idx_r < gcsg_pkg::GLYPH_COLS) ? glyph_byte : '0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (produce) begin
      idx_nxt = idx_r + 1'b1;
    end
    out_valid_nxt = produce ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entry_r <= q_entry;
    end
    if (produce) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/core/gcsg_checker.sv -----
// port-level checks for the glyph column stream generator, bound to the top level
module gcsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  logic wr_mode;
  assign wr_mode = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                   cfg_paddr[2] == gcsg_pkg::REG_DOUBLE_SIZE;

  // a stalled output transaction stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle right after reset");

  // size register reads back what was last written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(wr_mode) && cfg_paddr[2] == gcsg_pkg::REG_DOUBLE_SIZE
      |-> cfg_prdata[0] == $past(cfg_pwdata[0]))
    else $error("double_size readback mismatch");

  // the last byte of a character is always a blank spacer
  a_last_is_spacer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'h00)
    else $error("character end marker on a glyph column");

endmodule

bind glyph_column_stream_generator gcsg_checker u_gcsg_checker (.*);
